// File: src/bcu_pkg.sv
package bcu_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_DIVQ,       // top / n
    S_TEST,
    S_G1,         // gcd(n, d)
    S_G1_DIV,
    S_NR,         // n / g
    S_DR,         // d / g
    S_G2,         // gcd(r, dr)
    S_G2_DIV,
    S_R2,         // r / g
    S_DR2,        // dr / g
    S_DIVQ2,      // top / nr
    S_TEST2,
    S_MUL,
    S_DIVR,       // product / divisor
    S_NEXT,
    S_OUT
  } bcu_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// File: src/bcu_divider.sv
// Restoring divider, one quotient bit per cycle.
module bcu_divider import bcu_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output div_ctl_t         ctl,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [WIDTH:0]   rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [WIDTH:0]   trial;

  always_comb begin
    q_nxt = q_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[WIDTH-1:0], q_r[WIDTH-1]};
    if (start) begin
      q_nxt = dividend;
      d_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign ctl.done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r[WIDTH-1:0];
endmodule

// File: src/bcu_multiplier.sv
// Shift-add multiplier, one multiplier bit per cycle, low WIDTH bits kept.
module bcu_multiplier #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             done,
  output logic [WIDTH-1:0] product
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] a_r, a_nxt, b_r, b_nxt, p_r, p_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    p_nxt = p_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt = a;
      b_nxt = b;
      p_nxt = '0;
      cnt_nxt = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) p_nxt = p_r + a_r;
      a_nxt = {a_r[WIDTH-2:0], 1'b0};
      b_nxt = {1'b0, b_r[WIDTH-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign product = p_r;
endmodule

// File: src/binomial_coefficient_unit_core.sv
// Binomial coefficient unit: C(n, k) in WIDTH-bit unsigned arithmetic.
// Input channel in_*: in_tdata = {k_chosen, n_total}, n in the low 64 bits.
// Output channel out_*: out_tdata = coefficient, out_tuser = overflowed.
// One item is worked at a time; in_tready is high only while idle.
// Special cases (k zero, k one, k at least n) go straight from the check to output.
// Otherwise each loop step costs one division for top/n, a shift-add
// multiply and a division of the product by d (or the reduced d); a step
// that needs gcd reduction adds two Euclid loops, each of at most about
// 1.5*WIDTH iterations of a division, plus five divisions. All divisions
// share one restoring divider (one bit per cycle).
// The result sits in an output register until out_tready takes it; a stall
// holds the block, and no new item is taken until the result has gone.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_tvalid; any item in flight is discarded.
module binomial_coefficient_unit_core import bcu_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] n_total, [127:64] k_chosen
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // [63:0] coefficient
  output logic         out_tuser   // [0] overflowed
);
  localparam logic [WIDTH-1:0] TOP = '1;

  bcu_state_t state_r, state_nxt;
  logic [WIDTH-1:0] n_r, n_nxt, k_r, k_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [WIDTH-1:0] q_r, q_nxt, nr_r, nr_nxt, dr_r, dr_nxt;
  logic [WIDTH-1:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic             ovf_r, ovf_nxt, ov_r, ov_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  logic             red_r, red_nxt;   // step uses reduced n and d

  logic             dv_start, mul_start, mul_done;
  logic [WIDTH-1:0] dv_a, dv_b, dv_q, dv_rem, mul_p, mul_b;
  div_ctl_t         dv_ctl;

  bcu_divider #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .ctl(dv_ctl), .quotient(dv_q), .remainder(dv_rem)
  );

  bcu_multiplier #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(r_r), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; k_nxt = k_r; r_nxt = r_r; d_nxt = d_r; q_nxt = q_r;
    nr_nxt = nr_r; dr_nxt = dr_r; ga_nxt = ga_r; gb_nxt = gb_r;
    ovf_nxt = ovf_r; ov_nxt = ov_r; res_nxt = res_r; red_nxt = red_r;
    dv_start = 1'b0; dv_a = TOP; dv_b = n_r; mul_start = 1'b0; mul_b = n_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt = in_tdata[WIDTH-1:0];
          k_nxt = in_tdata[64 +: WIDTH];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ovf_nxt = 1'b0;
        r_nxt = WIDTH'(1);
        d_nxt = WIDTH'(1);
        if (k_r == '0) begin
          res_nxt = WIDTH'(1); state_nxt = S_OUT;
        end else if (k_r == WIDTH'(1)) begin
          res_nxt = n_r; state_nxt = S_OUT;
        end else if (k_r >= n_r) begin
          res_nxt = (k_r == n_r) ? WIDTH'(1) : '0; state_nxt = S_OUT;
        end else begin
          if (k_r > (n_r >> 1)) k_nxt = n_r - k_r;
          dv_start = 1'b1; dv_a = TOP; dv_b = n_r;
          state_nxt = S_DIVQ;
        end
      end
      S_DIVQ: if (dv_ctl.done) begin
        q_nxt = dv_q; state_nxt = S_TEST;
      end
      S_TEST: begin
        if (r_r >= q_r) begin
          if (n_r < d_r) begin ga_nxt = n_r; gb_nxt = d_r; end
          else begin ga_nxt = d_r; gb_nxt = n_r; end
          state_nxt = S_G1;
        end else begin
          red_nxt = 1'b0; mul_start = 1'b1; state_nxt = S_MUL;
        end
      end
      S_G1, S_G2: begin
        if (gb_r == '0) begin
          if (state_r == S_G1) begin
            dv_start = 1'b1; dv_a = n_r; dv_b = ga_r; state_nxt = S_NR;
          end else begin
            dv_start = 1'b1; dv_a = r_r; dv_b = ga_r; state_nxt = S_R2;
          end
        end else begin
          dv_start = 1'b1; dv_a = ga_r; dv_b = gb_r;
          state_nxt = (state_r == S_G1) ? S_G1_DIV : S_G2_DIV;
        end
      end
      S_G1_DIV, S_G2_DIV: if (dv_ctl.done) begin
        ga_nxt = gb_r; gb_nxt = dv_rem;
        state_nxt = (state_r == S_G1_DIV) ? S_G1 : S_G2;
      end
      S_NR: if (dv_ctl.done) begin
        nr_nxt = dv_q;
        dv_start = 1'b1; dv_a = d_r; dv_b = ga_r; state_nxt = S_DR;
      end
      S_DR: if (dv_ctl.done) begin
        dr_nxt = dv_q;
        if (dv_q < r_r) begin ga_nxt = dv_q; gb_nxt = r_r; end
        else begin ga_nxt = r_r; gb_nxt = dv_q; end
        state_nxt = S_G2;
      end
      S_R2: if (dv_ctl.done) begin
        r_nxt = dv_q;
        dv_start = 1'b1; dv_a = dr_r; dv_b = ga_r; state_nxt = S_DR2;
      end
      S_DR2: if (dv_ctl.done) begin
        dr_nxt = dv_q;
        dv_start = 1'b1; dv_a = TOP; dv_b = nr_r; state_nxt = S_DIVQ2;
      end
      S_DIVQ2: if (dv_ctl.done) begin
        q_nxt = dv_q; state_nxt = S_TEST2;
      end
      S_TEST2: begin
        if (r_r >= q_r) begin
          res_nxt = '0; ovf_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          red_nxt = 1'b1; mul_start = 1'b1; mul_b = nr_r; state_nxt = S_MUL;
        end
      end
      S_MUL: if (mul_done) begin
        dv_start = 1'b1; dv_a = mul_p; dv_b = red_r ? dr_r : d_r;
        state_nxt = S_DIVR;
      end
      S_DIVR: if (dv_ctl.done) begin
        r_nxt = dv_q; n_nxt = n_r - 1'b1; state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (d_r == k_r) begin
          res_nxt = r_r; state_nxt = S_OUT;
        end else begin
          d_nxt = d_r + 1'b1;
          dv_start = 1'b1; dv_a = TOP; dv_b = n_r; state_nxt = S_DIVQ;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
        end else if (out_tready) begin
          ov_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt; k_r <= k_nxt; r_r <= r_nxt; d_r <= d_nxt; q_r <= q_nxt;
    nr_r <= nr_nxt; dr_r <= dr_nxt; ga_r <= ga_nxt; gb_r <= gb_nxt;
    ovf_r <= ovf_nxt; res_r <= res_nxt; red_r <= red_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = 64'(res_r);
  assign out_tuser = ovf_r;
endmodule
